>>> sv/tls_pkg.sv
package tls_pkg;

   localparam int MAX_LINES_DEFAULT = 32;
   localparam int MAX_WIDTH         = 4096;
   localparam int MAX_HEIGHT        = 4096;

   localparam int PIX_W  = 8;
   localparam int GAIN_W = 16;
   localparam int OFS_W  = 25;
   localparam int THR_W  = 8;
   localparam int ROW_W  = 12;
   localparam int CNT_W  = 13;
   localparam int LNUM_W = 5;
   localparam int LTOT_W = 6;
   localparam int PROD_W = GAIN_W + PIX_W;
   localparam int SUM_W  = OFS_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [ROW_W-1:0] ROW_CAP =
      (MAX_HEIGHT - 1 > 4095) ? ROW_W'(4095) : ROW_W'(MAX_HEIGHT - 1);
   localparam logic [CNT_W-1:0] COUNT_CAP =
      (MAX_WIDTH > 8191) ? CNT_W'(8191) : CNT_W'(MAX_WIDTH);

   localparam logic [GAIN_W-1:0]       GAIN_RESET   = 16'd521;
   localparam logic signed [OFS_W-1:0] OFFSET_RESET = -25'sd12208;
   localparam logic [THR_W-1:0]        THRESH_RESET = 8'd128;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      REG_GAIN   = 2'd0,
      REG_OFFSET = 2'd1,
      REG_THRESH = 2'd2
   } reg_index_type;

   typedef enum logic {
      KIND_LINE  = 1'b0,
      KIND_FRAME = 1'b1
   } rec_kind_type;

   typedef struct packed {
      logic [GAIN_W-1:0]       gain;
      logic signed [OFS_W-1:0] offset;
      logic [THR_W-1:0]        threshold;
   } map_cfg_type;

   typedef struct packed {
      logic valid;
      logic bright;
      logic row_end;
      logic frame_end;
   } pix_flag_type;

   typedef struct packed {
      rec_kind_type       kind;
      logic [LNUM_W-1:0]  line_number;
      logic [ROW_W-1:0]   first_row;
      logic [ROW_W-1:0]   last_row;
      logic [LTOT_W-1:0]  lines_total;
      logic               overflowed;
      logic               is_last;
   } record_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              near_full;
   } queue_status_type;

endpackage

>>> sv/tls_interfaces.sv
interface tls_req_if import tls_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             row_end;
   logic             frame_end;

   modport source (output valid, pixel, row_end, frame_end, input ready);
   modport sink (input valid, pixel, row_end, frame_end, output ready);
endinterface

interface tls_rsp_if import tls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [LNUM_W-1:0] line_number;
   logic [ROW_W-1:0]  first_row;
   logic [ROW_W-1:0]  last_row;
   logic [LTOT_W-1:0] lines_total;
   logic              overflowed;
   logic              is_last;

   modport source (output valid, kind, line_number, first_row, last_row, lines_total,
                   overflowed, is_last, input ready);
   modport sink (input valid, kind, line_number, first_row, last_row, lines_total,
                 overflowed, is_last, output ready);
endinterface

>>> sv/text_line_segmenter_top.sv
// Text line segmenter. Takes one grayscale pixel per clock in raster order, maps it through
// gain and offset, thresholds it and counts bright pixels per row; rows whose count drops
// below the first row's count form a text line, and each closed line yields one record,
// followed by a frame done record on the last pixel of the frame. A pixel passes a
// three-stage map pipeline (input register, gain multiply, offset/round/threshold), so a
// record is written to a four-entry queue after the pixel that ends its row leaves the third stage. The
// block sustains one pixel per clock; the input holds off only while the queue has fewer
// than two free entries, since a frame end can produce two records in one cycle. Lines
// past MAX_LINES are dropped and reported in the frame done record.
module text_line_segmenter_top import tls_pkg::*; #(
   parameter int MAX_LINES = MAX_LINES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   tls_req_if.sink               req_ch,
   tls_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LC_W = $clog2(MAX_LINES + 1);

   map_cfg_type      cfg_ff;
   reg_index_type    csr_index;
   logic             csr_write;
   pix_flag_type     flag;
   queue_status_type qstat;
   logic             en;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] ref_ff, ref_in;
   logic             inside_ff, inside_in;
   logic [ROW_W-1:0] open_ff, open_in;
   logic [LC_W-1:0]  lcnt_ff, lcnt_in;
   logic             ovf_ff, ovf_in;

   logic             step, eor, inc, open_now, close_row, close_frame, closing, room;
   logic             emit, frame;
   logic [CNT_W-1:0] c, ref_now;
   logic [LC_W-1:0]  total;
   logic             ovf_after;
   record_type       rec_line, rec_frame, q_rec0, q_out;
   logic             q_we0, q_we1, q_valid;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain      <= GAIN_RESET;
         cfg_ff.offset    <= OFFSET_RESET;
         cfg_ff.threshold <= THRESH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_GAIN:   cfg_ff.gain      <= csr_pwdata[GAIN_W-1:0];
            REG_OFFSET: cfg_ff.offset    <= csr_pwdata[OFS_W-1:0];
            REG_THRESH: cfg_ff.threshold <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GAIN:   csr_prdata = CSR_DATA_W'(cfg_ff.gain);
         REG_OFFSET: csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.offset));
         REG_THRESH: csr_prdata = CSR_DATA_W'(cfg_ff.threshold);
         default:    csr_prdata = '0;
      endcase
   end

   assign en           = !qstat.near_full;
   assign req_ch.ready = en;

   tls_pixel_map u_map (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_ch.valid),
      .in_pixel     (req_ch.pixel),
      .in_row_end   (req_ch.row_end),
      .in_frame_end (req_ch.frame_end),
      .cfg          (cfg_ff),
      .flag         (flag)
   );

   always_comb begin
      step        = en && flag.valid;
      eor         = flag.row_end || flag.frame_end;
      inc         = flag.bright && (cnt_ff < COUNT_CAP);
      c           = cnt_ff + CNT_W'(inc);
      ref_now     = (row_ff == '0) ? c : ref_ff;
      open_now    = !inside_ff && (c < ref_now);
      close_row   = inside_ff && (c >= ref_now);
      close_frame = flag.frame_end && (open_now || (inside_ff && !close_row));
      closing     = eor && (close_row || close_frame);
      room        = lcnt_ff < LC_W'(MAX_LINES);
      emit        = step && closing && room;
      frame       = step && flag.frame_end;
      total       = lcnt_ff + LC_W'(emit);
      ovf_after   = ovf_ff || (closing && !room);

      rec_line.kind        = KIND_LINE;
      rec_line.line_number = LNUM_W'(lcnt_ff);
      rec_line.first_row   = open_now ? row_ff : open_ff;
      rec_line.last_row    = row_ff;
      rec_line.lines_total = '0;
      rec_line.overflowed  = 1'b0;
      rec_line.is_last     = 1'b0;

      rec_frame.kind        = KIND_FRAME;
      rec_frame.line_number = '0;
      rec_frame.first_row   = '0;
      rec_frame.last_row    = '0;
      rec_frame.lines_total = LTOT_W'(total);
      rec_frame.overflowed  = ovf_after;
      rec_frame.is_last     = 1'b1;

      q_we0  = emit || frame;
      q_we1  = emit && frame;
      q_rec0 = emit ? rec_line : rec_frame;
   end

   always_comb begin
      row_in    = row_ff;
      cnt_in    = cnt_ff;
      ref_in    = ref_ff;
      inside_in = inside_ff;
      open_in   = open_ff;
      lcnt_in   = lcnt_ff;
      ovf_in    = ovf_ff;
      if (step) begin
         cnt_in = c;
         if (eor) begin
            cnt_in  = '0;
            ref_in  = ref_now;
            lcnt_in = total;
            ovf_in  = ovf_after;
            if (open_now) begin
               inside_in = 1'b1;
               open_in   = row_ff;
            end else if (close_row) begin
               inside_in = 1'b0;
            end
            if (row_ff < ROW_CAP) begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         if (flag.frame_end) begin
            row_in    = '0;
            cnt_in    = '0;
            ref_in    = '0;
            inside_in = 1'b0;
            open_in   = '0;
            lcnt_in   = '0;
            ovf_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         cnt_ff    <= '0;
         ref_ff    <= '0;
         inside_ff <= 1'b0;
         open_ff   <= '0;
         lcnt_ff   <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         row_ff    <= row_in;
         cnt_ff    <= cnt_in;
         ref_ff    <= ref_in;
         inside_ff <= inside_in;
         open_ff   <= open_in;
         lcnt_ff   <= lcnt_in;
         ovf_ff    <= ovf_in;
      end
   end

   tls_rec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .we0       (q_we0),
      .rec0      (q_rec0),
      .we1       (q_we1),
      .rec1      (rec_frame),
      .out_valid (q_valid),
      .out_rec   (q_out),
      .out_ready (rsp_ch.ready),
      .status    (qstat)
   );

   assign rsp_ch.valid       = q_valid;
   assign rsp_ch.kind        = q_out.kind;
   assign rsp_ch.line_number = q_out.line_number;
   assign rsp_ch.first_row   = q_out.first_row;
   assign rsp_ch.last_row    = q_out.last_row;
   assign rsp_ch.lines_total = q_out.lines_total;
   assign rsp_ch.overflowed  = q_out.overflowed;
   assign rsp_ch.is_last     = q_out.is_last;

`ifndef NO_ASSERTIONS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (q_we0 || q_we1) |-> (qstat.count <= QCNT_W'(QDEPTH - 2)))
      else $error("record pushed without two free queue entries");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      frame |=> (row_ff == '0 && lcnt_ff == '0 && !inside_ff && !ovf_ff))
      else $error("row state not cleared after frame end");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      lcnt_ff <= LC_W'(MAX_LINES))
      else $error("line count beyond capacity");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> sv/tls_pixel_map.sv
module tls_pixel_map import tls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [PIX_W-1:0] in_pixel,
   input  logic             in_row_end,
   input  logic             in_frame_end,
   input  map_cfg_type      cfg,
   output pix_flag_type     flag
);

   logic              v1_ff, v2_ff, v3_ff;
   logic [PIX_W-1:0]  pix1_ff;
   logic              re1_ff, fe1_ff, re2_ff, fe2_ff, re3_ff, fe3_ff;
   logic [PROD_W-1:0] prod2_ff;
   logic [PROD_W-1:0] prod2_in;
   logic              bright3_ff;
   logic              bright3_in;

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] rounded;
   logic [SUM_W-10:0]       mag;
   logic [PIX_W-1:0]        mapped;

   assign prod2_in = PROD_W'(cfg.gain) * PROD_W'(pix1_ff);

   always_comb begin
      sum     = $signed({2'b00, prod2_ff}) + SUM_W'(cfg.offset);
      rounded = sum + SUM_W'(128);
      mag     = rounded[SUM_W-2:8];
      if (sum[SUM_W-1]) begin
         mapped = '0;
      end else if (mag > (SUM_W-9)'(255)) begin
         mapped = 8'hFF;
      end else begin
         mapped = mag[PIX_W-1:0];
      end
      bright3_in = mapped > cfg.threshold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix1_ff    <= in_pixel;
         re1_ff     <= in_row_end;
         fe1_ff     <= in_frame_end;
         prod2_ff   <= prod2_in;
         re2_ff     <= re1_ff;
         fe2_ff     <= fe1_ff;
         bright3_ff <= bright3_in;
         re3_ff     <= re2_ff;
         fe3_ff     <= fe2_ff;
      end
   end

   assign flag.valid     = v3_ff;
   assign flag.bright    = bright3_ff;
   assign flag.row_end   = re3_ff;
   assign flag.frame_end = fe3_ff;

endmodule

>>> sv/tls_rec_queue.sv
module tls_rec_queue import tls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             we0,
   input  record_type       rec0,
   input  logic             we1,
   input  record_type       rec1,
   output logic             out_valid,
   output record_type       out_rec,
   input  logic             out_ready,
   output queue_status_type status
);

   record_type        mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W-1:0] wr_in, rd_in, wr_second;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign pop       = out_valid && out_ready;
   assign wr_second = wr_ff + QPTR_W'(we0);
   assign wr_in     = wr_ff + QPTR_W'(we0) + QPTR_W'(we1);
   assign rd_in     = rd_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(we0) + QCNT_W'(we1) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         mem_ff[wr_ff] <= rec0;
      end
      if (we1) begin
         mem_ff[wr_second] <= rec1;
      end
   end

   assign out_valid        = count_ff != '0;
   assign out_rec          = mem_ff[rd_ff];
   assign status.count     = count_ff;
   assign status.near_full = count_ff > QCNT_W'(QDEPTH - 2);

endmodule
